FILE: rtl/hexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexp_pkg
// Shared types and codes for the hex record parser: record phases, result
// kinds, error codes, parser state and result layouts.
// ----------------------------------------------------------------------------
package hexp_pkg;

	// record phases
	localparam logic [2:0] PH_MARK   = 3'd0;
	localparam logic [2:0] PH_COUNT  = 3'd1;
	localparam logic [2:0] PH_ADDRHI = 3'd2;
	localparam logic [2:0] PH_ADDRLO = 3'd3;
	localparam logic [2:0] PH_TYPE   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_CHECK  = 3'd6;
	localparam logic [2:0] PH_TAIL   = 3'd7;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_EOF    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_MARK    = 3'd1;
	localparam logic [2:0] ERR_COUNT   = 3'd2;
	localparam logic [2:0] ERR_ADDRESS = 3'd3;
	localparam logic [2:0] ERR_TYPE    = 3'd4;
	localparam logic [2:0] ERR_DATA    = 3'd5;
	localparam logic [2:0] ERR_CHECK   = 3'd6;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef struct packed {
		logic [2:0]  phase;
		logic        digit_half;
		logic [3:0]  high_nibble;
		logic [7:0]  record_length;
		logic [7:0]  bytes_left;
		logic [15:0] base_address;
		logic [7:0]  running_sum;
		logic [15:0] records_done;
		logic        halted;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  data_value;
		logic [2:0]  error_code;
		logic [15:0] line_index;
	} result_t;

endpackage

FILE: rtl/hexp_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexp_char_if
// Character channel: valid/ready handshake with one text character and a
// restart flag per transaction.
// ----------------------------------------------------------------------------
interface hexp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       restart;

	modport source (output valid, output char_code, output restart, input ready);
	modport sink (input valid, input char_code, input restart, output ready);
endinterface

FILE: rtl/hexp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexp_result_if
// Result channel: valid/ready handshake carrying one parser result per
// transaction.
// ----------------------------------------------------------------------------
interface hexp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  data_value;
	logic [2:0]  error_code;
	logic [15:0] line_index;

	modport source (output valid, output kind, output address, output data_value,
		output error_code, output line_index, input ready);
	modport sink (input valid, input kind, input address, input data_value,
		input error_code, input line_index, output ready);
endinterface

FILE: rtl/intel_hex_record_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_core
// Streaming hex record parser: one text character per transaction in, at
// most one data byte, record, end-of-file or error result per character out.
//
//   channel  direction  payload
//   text     sink       char_code[7:0], restart
//   result   source     kind[1:0], address[15:0], data_value[7:0],
//                       error_code[2:0], line_index[15:0]
//
// A character is taken into an input register, decoded combinationally against
// the parser state and its result lands in the result register: the result is
// valid once it has passed the input register and then the result register, and
// one character per cycle is sustained while result.ready stays high.
// The result register lets a new character be accepted while a result waits.
// A held result stalls only the decode step; text.ready then drops once the
// input register is full. arst_n clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	hexp_char_if.sink     text,
	hexp_result_if.source result
);
	import hexp_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         restart_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         step_valid;
	result_t      step_res;
	logic         res_valid_q;
	result_t      res_q;
	logic         advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1    <= text.char_code;
			restart_s1 <= text.restart;
		end
	end

	hexp_step u_step (
		.st        (state_q),
		.char_code (char_s1),
		.restart   (restart_s1),
		.nxt       (state_nxt),
		.res_valid (step_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			res_valid_q <= step_valid;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid)
			res_q <= step_res;
	end

	assign result.valid      = res_valid_q;
	assign result.kind       = res_q.kind;
	assign result.address    = res_q.address;
	assign result.data_value = res_q.data_value;
	assign result.error_code = res_q.error_code;
	assign result.line_index = res_q.line_index;

	// error code only on error results
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind != KIND_ERROR |-> res_q.error_code == ERR_NONE)
		else $error("error code set on a non-error result");

	// data value only on data results
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind != KIND_DATA |-> res_q.data_value == 8'd0)
		else $error("data value set on a non-data result");

	// halt holds until restart
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted && !(advance && restart_s1) |=> state_q.halted)
		else $error("parser left halt without restart");

	// an error or end of file halts the parser
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_valid && (step_res.kind == KIND_ERROR || step_res.kind == KIND_EOF)
		|=> state_q.halted)
		else $error("terminal result did not halt the parser");

	// a halted parser produces nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.halted && advance |=> !res_valid_q)
		else $error("result produced while halted");

endmodule

FILE: rtl/hexp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexp_step
// Next-state and result logic for one character: start mark search, hex
// digit pairing, field decode, checksum check and error reporting.
// ----------------------------------------------------------------------------
module hexp_step (
	input  hexp_pkg::parse_state_t st,
	input  logic [7:0]             char_code,
	input  logic                   restart,
	output hexp_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output hexp_pkg::result_t      res
);
	import hexp_pkg::*;

	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	logic       is_hex;
	logic [3:0] nib;
	logic [7:0] byte_val;
	logic [7:0] offset;
	logic [7:0] sum_next;
	logic [2:0] digit_err;

	always_comb begin
		is_hex = 1'b1;
		nib    = 4'd0;
		case (char_code) inside
			[8'h30:8'h39]: nib = 4'(char_code - 8'h30);
			[8'h41:8'h46]: nib = 4'(char_code - 8'h37);
			[8'h61:8'h66]: nib = 4'(char_code - 8'h57);
			default:       is_hex = 1'b0;
		endcase
	end

	always_comb begin
		case (st.phase)
			PH_COUNT:            digit_err = ERR_COUNT;
			PH_ADDRHI, PH_ADDRLO: digit_err = ERR_ADDRESS;
			PH_TYPE:             digit_err = ERR_TYPE;
			PH_DATA:             digit_err = ERR_DATA;
			PH_CHECK:            digit_err = ERR_CHECK;
			default:             digit_err = ERR_NONE;
		endcase
	end

	assign byte_val = {st.high_nibble, nib};
	assign offset   = st.record_length - st.bytes_left;
	assign sum_next = st.running_sum + byte_val;

	always_comb begin
		nxt            = st;
		res_valid      = 1'b0;
		res            = '0;
		res.line_index = st.records_done;

		if (restart) begin
			nxt = '0;
		end else if (!st.halted) begin
			case (st.phase)
				PH_MARK: begin
					if (char_code == CH_COLON) begin
						nxt.phase       = PH_COUNT;
						nxt.digit_half  = 1'b0;
						nxt.running_sum = 8'd0;
					end else if (char_code == CH_NEWLINE) begin
						nxt.halted     = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_MARK;
					end
				end
				PH_TAIL: begin
					if (char_code == CH_NEWLINE)
						nxt.phase = PH_MARK;
				end
				default: begin
					if (char_code == CH_NEWLINE || !is_hex) begin
						nxt.halted     = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = (char_code == CH_NEWLINE) ? ERR_CHECK : digit_err;
					end else if (!st.digit_half) begin
						nxt.high_nibble = nib;
						nxt.digit_half  = 1'b1;
					end else begin
						nxt.digit_half = 1'b0;
						case (st.phase)
							PH_COUNT: begin
								nxt.record_length = byte_val;
								nxt.bytes_left    = byte_val;
								nxt.running_sum   = sum_next;
								nxt.phase         = PH_ADDRHI;
							end
							PH_ADDRHI: begin
								nxt.base_address = {byte_val, 8'd0};
								nxt.running_sum  = sum_next;
								nxt.phase        = PH_ADDRLO;
							end
							PH_ADDRLO: begin
								nxt.base_address = {st.base_address[15:8], byte_val};
								nxt.running_sum  = sum_next;
								nxt.phase        = PH_TYPE;
							end
							PH_TYPE: begin
								if (byte_val == 8'h01) begin
									nxt.halted  = 1'b1;
									res_valid   = 1'b1;
									res.kind    = KIND_EOF;
									res.address = st.base_address;
								end else if (byte_val != 8'h00) begin
									nxt.halted     = 1'b1;
									res_valid      = 1'b1;
									res.kind       = KIND_ERROR;
									res.error_code = ERR_TYPE;
								end else begin
									nxt.phase = (st.record_length != 8'd0) ? PH_DATA : PH_CHECK;
								end
							end
							PH_DATA: begin
								nxt.running_sum = sum_next;
								nxt.bytes_left  = st.bytes_left - 8'd1;
								if (st.bytes_left == 8'd1)
									nxt.phase = PH_CHECK;
								res_valid      = 1'b1;
								res.kind       = KIND_DATA;
								res.address    = st.base_address + {8'd0, offset};
								res.data_value = byte_val;
							end
							default: begin
								// checksum byte
								res_valid = 1'b1;
								if (sum_next != 8'd0) begin
									nxt.halted     = 1'b1;
									res.kind       = KIND_ERROR;
									res.error_code = ERR_CHECK;
								end else begin
									nxt.phase   = PH_TAIL;
									res.kind    = KIND_RECORD;
									res.address = st.base_address;
									if (st.records_done != COUNT_MAX)
										nxt.records_done = st.records_done + 16'd1;
								end
							end
						endcase
					end
				end
			endcase
		end
	end

endmodule
